[hw/rtl/mbr_pkg.sv]
package mbr_pkg;

    localparam int POS_W        = 10;
    localparam int TABLE_BASE   = 446;
    localparam int ENTRY_SIZE   = 16;
    localparam int NUM_ENTRIES  = 4;
    localparam int SECTOR_SIZE  = 512;
    localparam int ACTIVE_BIT   = 7;
    localparam int SECTOR_SHIFT = 9;
    localparam int SECT_W       = 32;
    localparam int BYTES_W      = SECT_W + SECTOR_SHIFT;
    localparam int SLOT_W       = 2;
    localparam int OFF_W        = 4;

    localparam logic [POS_W-1:0] TABLE_FIRST_POS = POS_W'(TABLE_BASE);
    localparam logic [POS_W-1:0] TABLE_END_POS   = POS_W'(TABLE_BASE + NUM_ENTRIES * ENTRY_SIZE);
    localparam logic [POS_W-1:0] LAST_SECTOR_POS = POS_W'(SECTOR_SIZE - 1);
    localparam logic [POS_W-1:0] POS_LIMIT       = POS_W'(SECTOR_SIZE);

    localparam logic [OFF_W-1:0] OFF_STATUS    = 4'd0;
    localparam logic [OFF_W-1:0] OFF_TYPE      = 4'd4;
    localparam logic [OFF_W-1:0] OFF_LAST_BYTE = 4'd15;
    localparam logic [1:0]       LANE_START    = 2'd2;
    localparam logic [1:0]       LANE_COUNT    = 2'd3;

    localparam logic [7:0] TYPE_CODE_RESET = 8'h47;

    typedef struct packed {
        logic              active;
        logic [7:0]        type_byte;
        logic [SECT_W-1:0] start_sector;
        logic [SECT_W-1:0] sector_count;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        entry_t            data;
    } entry_wr_t;

    function automatic logic entry_unused(entry_t e, logic [7:0] code);
        return (e.start_sector == '0) && (e.sector_count == '0) && !e.active
            && (e.type_byte != code);
    endfunction

endpackage

[hw/rtl/mbr_ram.sv]
module mbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/mbr_entry_asm.sv]
module mbr_entry_asm (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [7:0]        byte_value,
    input  logic              end_of_image,
    output mbr_pkg::entry_wr_t wr,
    output logic              table_done
);

    logic [mbr_pkg::POS_W-1:0]  pos_reg;
    logic [mbr_pkg::POS_W-1:0]  pos_next;
    logic [mbr_pkg::POS_W-1:0]  rel;
    logic [mbr_pkg::OFF_W-1:0]  off;
    logic [mbr_pkg::SLOT_W-1:0] slot;
    logic                       in_table;
    logic                       active_reg;
    logic                       active_next;
    logic [7:0]                 type_reg;
    logic [7:0]                 type_next;
    logic [mbr_pkg::SECT_W-1:0] start_reg;
    logic [mbr_pkg::SECT_W-1:0] start_next;
    logic [mbr_pkg::SECT_W-1:0] count_reg;
    logic [mbr_pkg::SECT_W-1:0] count_next;

    assign rel      = pos_reg - mbr_pkg::TABLE_FIRST_POS;
    assign off      = rel[mbr_pkg::OFF_W-1:0];
    assign slot     = rel[mbr_pkg::OFF_W +: mbr_pkg::SLOT_W];
    assign in_table = (pos_reg >= mbr_pkg::TABLE_FIRST_POS) && (pos_reg < mbr_pkg::TABLE_END_POS);

    // Fields are gathered in registers; the whole entry goes to memory on its last byte.
    always_comb
    begin
        active_next = active_reg;
        type_next   = type_reg;
        start_next  = start_reg;
        count_next  = count_reg;
        if (accept && in_table)
        begin
            if (off == mbr_pkg::OFF_STATUS)
            begin
                active_next = byte_value[mbr_pkg::ACTIVE_BIT];
            end
            if (off == mbr_pkg::OFF_TYPE)
            begin
                type_next = byte_value;
            end
            if (off[3:2] == mbr_pkg::LANE_START)
            begin
                start_next[off[1:0]*8 +: 8] = byte_value;
            end
            if (off[3:2] == mbr_pkg::LANE_COUNT)
            begin
                count_next[off[1:0]*8 +: 8] = byte_value;
            end
        end
    end

    always_comb
    begin
        wr.en                = accept && in_table && (off == mbr_pkg::OFF_LAST_BYTE);
        wr.addr              = slot;
        wr.data.active       = active_next;
        wr.data.type_byte    = type_next;
        wr.data.start_sector = start_next;
        wr.data.sector_count = count_next;
    end

    assign table_done = accept && (pos_reg == mbr_pkg::LAST_SECTOR_POS);

    always_comb
    begin
        pos_next = pos_reg;
        if (accept)
        begin
            if (end_of_image)
            begin
                pos_next = '0;
            end
            else if (pos_reg < mbr_pkg::POS_LIMIT)
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        active_reg <= active_next;
        type_reg   <= type_next;
        start_reg  <= start_next;
        count_reg  <= count_next;
    end

endmodule

[hw/rtl/mbr_emit.sv]
module mbr_emit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        table_done,
    input  logic [7:0]                  type_code,
    input  mbr_pkg::entry_t             rdata,
    output logic                        re,
    output logic [mbr_pkg::SLOT_W-1:0]  raddr,
    output logic                        busy,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  entry_index,
    output logic                        type_matches,
    output logic                        is_active,
    output logic [mbr_pkg::BYTES_W-1:0] start_bytes,
    output logic [mbr_pkg::BYTES_W-1:0] length_bytes,
    output logic                        last_record
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FIRST = 2'd1;
    localparam logic [1:0] ST_NEXT  = 2'd2;
    localparam logic [1:0] ST_LAST  = 2'd3;
    localparam logic [mbr_pkg::SLOT_W-1:0] SLOT_MAX = mbr_pkg::SLOT_W'(mbr_pkg::NUM_ENTRIES - 1);

    logic [1:0]                 state_reg;
    logic [1:0]                 state_next;
    logic [mbr_pkg::SLOT_W-1:0] rd_idx_reg;
    logic [mbr_pkg::SLOT_W-1:0] rd_idx_next;
    mbr_pkg::entry_t            cur_reg;
    mbr_pkg::entry_t            cur_next;
    logic [mbr_pkg::SLOT_W-1:0] cur_idx_reg;
    logic [mbr_pkg::SLOT_W-1:0] cur_idx_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic                       out_free;
    logic                       load_out;
    logic                       load_last;
    logic                       rd_unused;

    logic [1:0]                 idx_out_reg;
    logic                       match_out_reg;
    logic                       active_out_reg;
    logic [mbr_pkg::BYTES_W-1:0] start_out_reg;
    logic [mbr_pkg::BYTES_W-1:0] length_out_reg;
    logic                       last_out_reg;

    assign out_free  = !out_valid_reg || !out_stall;
    assign rd_unused = mbr_pkg::entry_unused(rdata, type_code);

    // Entries are read one ahead so the record in hand knows whether it is the final one.
    // Memory read data holds while re is low, so a stalled output simply waits.
    always_comb
    begin
        state_next   = state_reg;
        rd_idx_next  = rd_idx_reg;
        cur_next     = cur_reg;
        cur_idx_next = cur_idx_reg;
        re           = 1'b0;
        raddr        = rd_idx_reg;
        load_out     = 1'b0;
        load_last    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (table_done)
                begin
                    re          = 1'b1;
                    raddr       = '0;
                    rd_idx_next = '0;
                    state_next  = ST_FIRST;
                end
            end
            ST_FIRST:
            begin
                if (rd_unused)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    cur_next     = rdata;
                    cur_idx_next = rd_idx_reg;
                    re           = 1'b1;
                    raddr        = rd_idx_reg + 1'b1;
                    rd_idx_next  = rd_idx_reg + 1'b1;
                    state_next   = ST_NEXT;
                end
            end
            ST_NEXT:
            begin
                if (out_free)
                begin
                    load_out  = 1'b1;
                    load_last = rd_unused;
                    if (rd_unused)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cur_next     = rdata;
                        cur_idx_next = rd_idx_reg;
                        if (rd_idx_reg == SLOT_MAX)
                        begin
                            state_next = ST_LAST;
                        end
                        else
                        begin
                            re          = 1'b1;
                            raddr       = rd_idx_reg + 1'b1;
                            rd_idx_next = rd_idx_reg + 1'b1;
                        end
                    end
                end
            end
            ST_LAST:
            begin
                if (out_free)
                begin
                    load_out   = 1'b1;
                    load_last  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        cur_idx_reg <= cur_idx_next;
        if (load_out)
        begin
            idx_out_reg    <= cur_idx_reg;
            match_out_reg  <= (cur_reg.type_byte == type_code);
            active_out_reg <= cur_reg.active;
            start_out_reg  <= {cur_reg.start_sector, {mbr_pkg::SECTOR_SHIFT{1'b0}}};
            length_out_reg <= {cur_reg.sector_count, {mbr_pkg::SECTOR_SHIFT{1'b0}}};
            last_out_reg   <= load_last;
        end
    end

    assign busy         = (state_reg != ST_IDLE);
    assign out_valid    = out_valid_reg;
    assign entry_index  = idx_out_reg;
    assign type_matches = match_out_reg;
    assign is_active    = active_out_reg;
    assign start_bytes  = start_out_reg;
    assign length_bytes = length_out_reg;
    assign last_record  = last_out_reg;

endmodule

[hw/rtl/mbr_partition_table_parser.sv]
// MBR partition table parser.
// Input channel: one image byte per beat (byte_value, end_of_image) on in_valid / in_stall.
// Output channel: one partition record per beat on out_valid / out_stall.
// Configuration: cfg_write_en loads cfg_write_data as the recognized type code
// (0x47 after reset); write it only while no image is in flight.
// Bytes are taken one per cycle while in_stall is low. The four table entries are
// gathered into a four-entry memory, one write per completed 16-byte entry. On
// the 512th byte the block reads the memory one entry per cycle unless the output
// stalls, one entry ahead of the record it is building, and stalls its input until
// the last record sits in the output register: each entry is read from memory,
// held as the record in hand, then loaded into the output register, and the next
// records follow one per cycle while out_stall is low.
// Up to four records follow per image; output ends before the first unused entry.
// A stalled record holds in the output register; the sequencer waits behind it.
// Reset clears the byte position, the sequencer and the output valid; the entry
// memory needs no clearing since every entry is rewritten before it is read.
module mbr_partition_table_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic [7:0]  cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  byte_value,
    input  logic        end_of_image,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  entry_index,
    output logic        type_matches,
    output logic        is_active,
    output logic [40:0] start_bytes,
    output logic [40:0] length_bytes,
    output logic        last_record
);

    logic                       accept;
    logic                       busy;
    logic                       table_done;
    logic [7:0]                 type_code_reg;
    mbr_pkg::entry_wr_t         wr;
    logic                       re;
    logic [mbr_pkg::SLOT_W-1:0] raddr;
    logic [mbr_pkg::ENTRY_W-1:0] rdata_raw;
    mbr_pkg::entry_t            rdata;

    assign in_stall = busy;
    assign accept   = in_valid && !busy;
    assign rdata    = mbr_pkg::entry_t'(rdata_raw);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_code_reg <= mbr_pkg::TYPE_CODE_RESET;
        end
        else if (cfg_write_en)
        begin
            type_code_reg <= cfg_write_data;
        end
    end

    mbr_entry_asm u_asm (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .byte_value   (byte_value),
        .end_of_image (end_of_image),
        .wr           (wr),
        .table_done   (table_done)
    );

    mbr_ram #(
        .WIDTH (mbr_pkg::ENTRY_W),
        .DEPTH (mbr_pkg::NUM_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    mbr_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .table_done   (table_done),
        .type_code    (type_code_reg),
        .rdata        (rdata),
        .re           (re),
        .raddr        (raddr),
        .busy         (busy),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .entry_index  (entry_index),
        .type_matches (type_matches),
        .is_active    (is_active),
        .start_bytes  (start_bytes),
        .length_bytes (length_bytes),
        .last_record  (last_record)
    );

endmodule

[hw/rtl/mbr_checker.sv]
module mbr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  entry_index,
    input logic        type_matches,
    input logic        is_active,
    input logic [40:0] start_bytes,
    input logic [40:0] length_bytes,
    input logic        last_record
);

    logic       mid_image_reg;
    logic [1:0] exp_idx_reg;

    // Tracks where the record sequence of the current image stands.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_image_reg <= 1'b0;
            exp_idx_reg   <= '0;
        end
        else if (out_valid && !out_stall)
        begin
            mid_image_reg <= !last_record;
            exp_idx_reg   <= entry_index + 1'b1;
        end
    end

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(entry_index) && $stable(last_record)
            && $stable(start_bytes) && $stable(length_bytes) && $stable(type_matches)
            && $stable(is_active))
        else $error("record changed while stalled");

    a_first_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !mid_image_reg |-> entry_index == 2'd0)
        else $error("first record of an image is not slot zero");

    a_next_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mid_image_reg |-> entry_index == exp_idx_reg)
        else $error("record slots out of order");

    a_slot_three_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && entry_index == 2'd3 |-> last_record)
        else $error("slot three record not marked last");

    a_sector_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> start_bytes[8:0] == 9'd0 && length_bytes[8:0] == 9'd0)
        else $error("byte offsets not sector aligned");

endmodule

bind mbr_partition_table_parser mbr_checker u_mbr_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .entry_index  (entry_index),
    .type_matches (type_matches),
    .is_active    (is_active),
    .start_bytes  (start_bytes),
    .length_bytes (length_bytes),
    .last_record  (last_record)
);

[tb/mbr_record_checker.sv]
`timescale 1ns / 1ps

module mbr_record_checker
    import mbr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write_en,
    input  logic [7:0]         cfg_write_data,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [7:0]         byte_value,
    input  logic               end_of_image,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [SLOT_W-1:0]  entry_index,
    input  logic               type_matches,
    input  logic               is_active,
    input  logic [BYTES_W-1:0] start_bytes,
    input  logic [BYTES_W-1:0] length_bytes,
    input  logic               last_record,
    output int                 mismatch_count,
    output int                 records_due,
    output int                 records_seen
);

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               type_hit;
        logic               active;
        logic [BYTES_W-1:0] start_b;
        logic [BYTES_W-1:0] length_b;
        logic               final_rec;
    } part_record_t;

    logic [7:0]       type_code;
    logic [POS_W-1:0] byte_pos;
    entry_t           slots [NUM_ENTRIES];
    part_record_t     owed_records [$];
    int               errors = 0;
    int               seen = 0;

    // An entry stays in the list unless it is all zero, inactive and of another type.
    function automatic logic slot_in_use(entry_t e);
        return e.start_sector != '0 || e.sector_count != '0 || e.active
            || e.type_byte == type_code;
    endfunction

    function automatic void capture_table_byte(logic [POS_W-1:0] pos, logic [7:0] b);
        logic [POS_W-1:0]  rel;
        logic [SLOT_W-1:0] s;
        logic [OFF_W-1:0]  off;
        rel = pos - TABLE_FIRST_POS;
        s   = rel[OFF_W +: SLOT_W];
        off = rel[OFF_W-1:0];
        if (off == OFF_STATUS)
            slots[s].active = b[ACTIVE_BIT];
        else if (off == OFF_TYPE)
            slots[s].type_byte = b;
        else if (off[3:2] == LANE_START)
            slots[s].start_sector[8*off[1:0] +: 8] = b;
        else if (off[3:2] == LANE_COUNT)
            slots[s].sector_count[8*off[1:0] +: 8] = b;
    endfunction

    function automatic void queue_records();
        int           n;
        part_record_t r;
        n = 0;
        while (n < NUM_ENTRIES && slot_in_use(slots[n]))
            n++;
        for (int i = 0; i < n; i++)
        begin
            r.slot      = SLOT_W'(i);
            r.type_hit  = (slots[i].type_byte == type_code);
            r.active    = slots[i].active;
            r.start_b   = BYTES_W'(slots[i].start_sector) << SECTOR_SHIFT;
            r.length_b  = BYTES_W'(slots[i].sector_count) << SECTOR_SHIFT;
            r.final_rec = (i == n - 1);
            owed_records.insert(owed_records.size(), r);
        end
    endfunction

    function automatic void compare_field(string name, logic [BYTES_W-1:0] want,
                                          logic [BYTES_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            errors++;
        end
    endfunction

    function automatic void check_record();
        part_record_t want;
        if (owed_records.size() == 0)
        begin
            $error("record for slot %0d arrived with none expected", entry_index);
            errors++;
            return;
        end
        want = owed_records.pop_front();
        compare_field("entry_index", BYTES_W'(want.slot), BYTES_W'(entry_index));
        compare_field("type_matches", BYTES_W'(want.type_hit), BYTES_W'(type_matches));
        compare_field("is_active", BYTES_W'(want.active), BYTES_W'(is_active));
        compare_field("start_bytes", want.start_b, start_bytes);
        compare_field("length_bytes", want.length_b, length_bytes);
        compare_field("last_record", BYTES_W'(want.final_rec), BYTES_W'(last_record));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            type_code = TYPE_CODE_RESET;
            byte_pos  = '0;
            owed_records.delete();
        end
        else
        begin
            if (cfg_write_en)
                type_code = cfg_write_data;
            if (in_valid && !in_stall)
            begin
                if (byte_pos >= TABLE_FIRST_POS && byte_pos < TABLE_END_POS)
                    capture_table_byte(byte_pos, byte_value);
                if (byte_pos == LAST_SECTOR_POS)
                    queue_records();
                // The position parks at the sector size until the image ends.
                if (end_of_image)
                    byte_pos = '0;
                else if (byte_pos < POS_LIMIT)
                    byte_pos = byte_pos + 1'b1;
            end
            if (out_valid && !out_stall)
            begin
                check_record();
                seen++;
            end
        end
        mismatch_count <= errors;
        records_due    <= owed_records.size();
        records_seen   <= seen;
    end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import mbr_pkg::*;

    localparam int         IMAGE_MAX      = 1280;
    localparam int         SETTLE_CYCLES  = 12;
    localparam int         WATCHDOG_LIMIT = 400;
    localparam int         RECORD_GOAL    = 90;
    localparam int         PHASE_CAP      = 40;
    localparam logic [7:0] ACTIVE_MASK    = 8'(1 << ACTIVE_BIT);

    typedef enum {ENT_UNUSED, ENT_RANDOM, ENT_EXTREME, ENT_ZERO_KEPT} entry_kind_t;
    typedef enum {IMG_WELL_FORMED, IMG_SHORT, IMG_LONG, IMG_NOISE} image_kind_t;
    typedef enum {STALL_NONE, STALL_COIN, STALL_PERIODIC} stall_mode_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_write_en;
    logic [7:0]         cfg_write_data;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         byte_value;
    logic               end_of_image;
    logic               out_valid;
    logic               out_stall;
    logic [SLOT_W-1:0]  entry_index;
    logic               type_matches;
    logic               is_active;
    logic [BYTES_W-1:0] start_bytes;
    logic [BYTES_W-1:0] length_bytes;
    logic               last_record;

    int mismatch_count;
    int records_due;
    int records_seen;

    logic [7:0] img [IMAGE_MAX];
    logic [7:0] type_code_now;
    int         burst_left;
    bit         steady;
    int         idle_cycles = 0;
    int         images_sent = 0;
    int         bytes_sent = 0;
    int         short_images = 0;
    int         long_images = 0;
    int         codes_used = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    mbr_partition_table_parser dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .byte_value     (byte_value),
        .end_of_image   (end_of_image),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .entry_index    (entry_index),
        .type_matches   (type_matches),
        .is_active      (is_active),
        .start_bytes    (start_bytes),
        .length_bytes   (length_bytes),
        .last_record    (last_record)
    );

    mbr_record_checker record_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .byte_value     (byte_value),
        .end_of_image   (end_of_image),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .entry_index    (entry_index),
        .type_matches   (type_matches),
        .is_active      (is_active),
        .start_bytes    (start_bytes),
        .length_bytes   (length_bytes),
        .last_record    (last_record),
        .mismatch_count (mismatch_count),
        .records_due    (records_due),
        .records_seen   (records_seen)
    );

    function automatic logic [7:0] code_other_than(logic [7:0] c);
        return c + 8'($urandom_range(1, 255));
    endfunction

    function automatic void fill_image();
        for (int i = 0; i < IMAGE_MAX; i++)
            img[i] = 8'($urandom);
    endfunction

    function automatic void put_fields(int slot, logic [7:0] status, logic [7:0] kind_byte,
                                       logic [31:0] start_sec, logic [31:0] count_sec);
        int base;
        base = TABLE_BASE + slot * ENTRY_SIZE;
        img[base + OFF_STATUS] = status;
        img[base + OFF_TYPE]   = kind_byte;
        for (int k = 0; k < 4; k++)
        begin
            img[base + 4*LANE_START + k] = start_sec[8*k +: 8];
            img[base + 4*LANE_COUNT + k] = count_sec[8*k +: 8];
        end
    endfunction

    function automatic void put_entry(int slot, entry_kind_t kind);
        logic [7:0]  st;
        logic [7:0]  tb;
        logic [31:0] extremes [4];
        extremes = '{32'h0, 32'h1, 32'h8000_0000, 32'hFFFF_FFFF};
        st = 8'($urandom);
        tb = ($urandom_range(0, 2) == 0) ? type_code_now : 8'($urandom);
        case (kind)
            ENT_UNUSED:
                put_fields(slot, st & ~ACTIVE_MASK, code_other_than(type_code_now), '0, '0);
            ENT_RANDOM:
                put_fields(slot, st, tb, $urandom, $urandom);
            ENT_EXTREME:
                put_fields(slot, $urandom_range(0, 1) ? 8'hFF : 8'h00,
                           $urandom_range(0, 1) ? tb : 8'hFF,
                           extremes[$urandom_range(0, 3)], extremes[$urandom_range(0, 3)]);
            default:
                // Zero sectors, kept in the list by the active flag or by the type code.
                if ($urandom_range(0, 1))
                    put_fields(slot, st | ACTIVE_MASK, code_other_than(type_code_now), '0, '0);
                else
                    put_fields(slot, st & ~ACTIVE_MASK, type_code_now, '0, '0);
        endcase
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic eoi);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = steady ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid     <= 1'b1;
        byte_value   <= b;
        end_of_image <= eoi;
        do @(posedge clk); while (in_stall);
        burst_left--;
    endtask

    task automatic send_image(input int len);
        steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
            send_byte(img[i], i == len - 1);
        images_sent++;
        bytes_sent += len;
        if (len < SECTOR_SIZE)
            short_images++;
        else if (len > SECTOR_SIZE)
            long_images++;
    endtask

    // Waits until every owed record has come out and the sequencer has gone quiet.
    task automatic drain();
        in_valid <= 1'b0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        while (records_due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_type_code(input logic [7:0] v);
        drain();
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        type_code_now = v;
        codes_used++;
    endtask

    task automatic random_image(input image_kind_t kind);
        int used;
        fill_image();
        if (kind != IMG_NOISE)
        begin
            used = $urandom_range(0, NUM_ENTRIES);
            for (int s = 0; s < NUM_ENTRIES; s++)
            begin
                if (s < used)
                    put_entry(s, entry_kind_t'($urandom_range(ENT_RANDOM, ENT_ZERO_KEPT)));
                else if (s == used)
                    put_entry(s, ENT_UNUSED);
                else
                    put_entry(s, entry_kind_t'($urandom_range(ENT_UNUSED, ENT_ZERO_KEPT)));
            end
        end
        case (kind)
            IMG_SHORT:
                send_image($urandom_range(0, 2) == 0 ? SECTOR_SIZE - 1
                                                     : $urandom_range(1, SECTOR_SIZE - 1));
            IMG_LONG:
                send_image($urandom_range(SECTOR_SIZE + 1, IMAGE_MAX));
            default:
                send_image(SECTOR_SIZE);
        endcase
    endtask

    initial
    begin
        stall_mode_t mode;
        int          span;
        int          period;
        out_stall = 1'b0;
        forever
        begin
            mode   = stall_mode_t'($urandom_range(STALL_NONE, STALL_PERIODIC));
            span   = $urandom_range(16, 400);
            period = $urandom_range(2, 12);
            for (int tick = 0; tick < span; tick++)
            begin
                @(posedge clk);
                case (mode)
                    STALL_NONE: out_stall <= 1'b0;
                    STALL_COIN: out_stall <= 1'($urandom_range(0, 1));
                    default:    out_stall <= (tick % period != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_write_en || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $error("no beat moved for %0d cycles", WATCHDOG_LIMIT);
            $display("** mbr_partition_table_parser: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        logic [7:0]  next_code;
        image_kind_t kind;
        int          pick;
        int          phases;
        rst_n          = 1'b0;
        cfg_write_en   = 1'b0;
        cfg_write_data = '0;
        in_valid       = 1'b0;
        byte_value     = '0;
        end_of_image   = 1'b0;
        type_code_now  = TYPE_CODE_RESET;
        burst_left     = 0;
        steady         = 1'b0;
        phases         = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Four records with the sector fields and flags at their extremes.
        fill_image();
        put_fields(0, 8'h80, TYPE_CODE_RESET, '1, '1);
        put_fields(1, 8'h00, 8'h00, 32'h0, 32'h1);
        put_fields(2, 8'h7F, 8'hFF, 32'h1, 32'h0);
        put_fields(3, 8'hFF, TYPE_CODE_RESET - 8'h1, 32'h8000_0000, 32'h7FFF_FFFF);
        send_image(SECTOR_SIZE);
        // Images that end before the last byte of the sector owe nothing.
        send_image(SECTOR_SIZE - 1);
        send_image(1);
        send_image(IMAGE_MAX);
        put_fields(0, 8'h00, 8'h00, '0, '0);
        send_image(SECTOR_SIZE);
        put_fields(0, 8'h00, TYPE_CODE_RESET, '0, '0);
        put_fields(1, 8'h80, 8'h00, '0, '0);
        put_fields(2, 8'h7F, 8'h48, '0, 32'd5);
        put_fields(3, 8'h7F, 8'h00, '0, '0);
        send_image(SECTOR_SIZE);
        put_fields(1, 8'h00, 8'h01, '0, '0);
        send_image(SECTOR_SIZE);

        // With a code of zero an all-zero entry is still a partition.
        set_type_code(8'h00);
        for (int s = 0; s < NUM_ENTRIES; s++)
            put_fields(s, 8'h00, 8'h00, '0, '0);
        send_image(SECTOR_SIZE);
        set_type_code(8'hFF);
        send_image(SECTOR_SIZE);
        put_fields(0, 8'h00, 8'hFF, '0, '0);
        send_image(SECTOR_SIZE);

        while (records_seen < RECORD_GOAL && phases < PHASE_CAP)
        begin
            case ($urandom_range(0, 4))
                0:       next_code = 8'h00;
                1:       next_code = 8'hFF;
                2:       next_code = TYPE_CODE_RESET;
                default: next_code = 8'($urandom);
            endcase
            set_type_code(next_code);
            repeat ($urandom_range(2, 5))
            begin
                pick = $urandom_range(0, 19);
                if (pick < 12)
                    kind = IMG_WELL_FORMED;
                else if (pick < 15)
                    kind = IMG_SHORT;
                else if (pick < 17)
                    kind = IMG_LONG;
                else
                    kind = IMG_NOISE;
                random_image(kind);
            end
            phases++;
        end
        drain();

        $display("Checked %0d partition records from %0d images (%0d bytes, %0d short, %0d long).",
                 records_seen, images_sent, bytes_sent, short_images, long_images);
        $display("The recognized type code was rewritten %0d times across the run.", codes_used);
        if (mismatch_count == 0 && records_due == 0)
            $display("** mbr_partition_table_parser: PASSED **");
        else
            $display("** mbr_partition_table_parser: FAILED **");
        $finish;
    end

endmodule
